### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define PAT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// types, codes and helpers shared by the peer address table
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_ZERO    = 3'd1,
        ST_PRIVATE = 3'd2,
        ST_PRESENT = 3'd3,
        ST_ABSENT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // command handed from the front to the back
    typedef struct packed {
        op_t               op;
        logic              resolved;
        status_t           status;
        logic [ADDR_W-1:0] address;
    } cmd_t;

    // 10/8, 172.16/12, 192.168/16, 169.254/16
    function automatic logic is_private(input logic [ADDR_W-1:0] a);
        logic [7:0] o1;
        logic [7:0] o2;
        o1 = a[31:24];
        o2 = a[23:16];
        return (o1 == 8'd10)
            || (o1 == 8'd172 && o2 >= 8'd16 && o2 <= 8'd31)
            || (o1 == 8'd192 && o2 == 8'd168)
            || (o1 == 8'd169 && o2 == 8'd254);
    endfunction

endpackage

### hdl/pat_if.sv
// ----------------------------------------------------------------------------
// pat_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface pat_req_if;
    logic                        valid;
    logic                        ready;
    logic [pat_pkg::KIND_W-1:0]  kind;
    logic [pat_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

interface pat_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pat_pkg::STATUS_W-1:0]  status;
    logic [pat_pkg::POS_W-1:0]     position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

### hdl/pat_front.sv
// ----------------------------------------------------------------------------
// pat_front
// accepts request transactions, holds the filter register and classifies
// ----------------------------------------------------------------------------
module pat_front
(
    input  logic             clk,
    input  logic             rst_n,
    pat_req_if.sink          req,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             clearing,
    input  logic             queue_full,
    output logic             push,
    output pat_pkg::cmd_t    cmd
);

    logic filter_reg;
    logic filter_next;

    assign filter_next = cfg_we ? cfg_wdata : filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= 1'b0;
        end
        else
        begin
            filter_reg <= filter_next;
        end
    end

    assign req.ready = !queue_full && !clearing;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        cmd.address  = req.address;
        cmd.resolved = 1'b0;
        cmd.status   = pat_pkg::ST_DONE;
        unique case (req.kind)
            pat_pkg::KIND_INSERT: cmd.op = pat_pkg::OP_INSERT;
            pat_pkg::KIND_REMOVE: cmd.op = pat_pkg::OP_REMOVE;
            default:              cmd.op = pat_pkg::OP_LOOKUP;
        endcase
        // cases settled without touching the table
        if (cmd.op == pat_pkg::OP_INSERT)
        begin
            if (req.address == '0)
            begin
                cmd.resolved = 1'b1;
                cmd.status   = pat_pkg::ST_ZERO;
            end
            else if (filter_reg && pat_pkg::is_private(req.address))
            begin
                cmd.resolved = 1'b1;
                cmd.status   = pat_pkg::ST_PRIVATE;
            end
        end
        else if (req.address == '0)
        begin
            cmd.resolved = 1'b1;
            cmd.status   = pat_pkg::ST_ABSENT;
        end
    end

endmodule

### hdl/pat_queue.sv
// ----------------------------------------------------------------------------
// pat_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module pat_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pat_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output pat_pkg::cmd_t    head
);

    pat_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/pat_back.sv
// ----------------------------------------------------------------------------
// pat_back
// address memory, scan/insert/compact sequencer and response register
// ----------------------------------------------------------------------------
module pat_back
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  pat_pkg::cmd_t    head,
    output logic             pop,
    output logic             clearing,
    pat_rsp_if.source        rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW   = AW + 1;
    localparam int PosW = pat_pkg::POS_W;
    localparam int AddrW = pat_pkg::ADDR_W;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    pat_pkg::op_t      op_reg, op_next;
    logic [AddrW-1:0]  addr_reg, addr_next;
    pat_pkg::status_t  res_status_reg, res_status_next;
    logic [AW-1:0]     res_pos_reg, res_pos_next;
    logic              out_valid_reg, out_valid_next;
    pat_pkg::status_t  out_status_reg, out_status_next;
    logic [PosW-1:0]   out_pos_reg, out_pos_next;

    logic [AddrW-1:0]  mem [DEPTH];
    logic [AddrW-1:0]  rdata_reg;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AddrW-1:0]  wdata;
    logic [AW-1:0]     raddr;

    logic              hit;
    logic              at_end;
    logic [AW-1:0]     ins_slot;
    logic [PW-1:0]     cmp_plus1;
    logic [PW-1:0]     idx_plus2;

    assign clearing     = (state_reg == S_CLEAR);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;

    assign hit       = (rdata_reg == addr_reg);
    assign at_end    = (rdata_reg == '0) || (cmp_idx_reg == LAST);
    assign ins_slot  = (ptr_reg >= PW'(DEPTH)) ? '0 : ptr_reg[AW-1:0];
    assign cmp_plus1 = {1'b0, cmp_idx_reg} + PW'(1);
    assign idx_plus2 = {1'b0, idx_reg} + PW'(2);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        pop             = 1'b0;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = '0;
        raddr           = idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop          = 1'b1;
                    op_next      = head.op;
                    addr_next    = head.address;
                    res_pos_next = '0;
                    if (head.resolved)
                    begin
                        res_status_next = head.status;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        // first read goes out now, compare starts next cycle
                        raddr        = '0;
                        cmp_idx_next = '0;
                        idx_next     = AW'(1);
                        state_next   = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                raddr        = idx_reg;
                cmp_idx_next = idx_reg;
                idx_next     = (idx_reg == LAST) ? idx_reg : idx_reg + AW'(1);
                if (hit)
                begin
                    unique case (op_reg)
                        pat_pkg::OP_INSERT:
                        begin
                            res_status_next = pat_pkg::ST_PRESENT;
                            state_next      = S_RESP;
                        end
                        pat_pkg::OP_REMOVE:
                        begin
                            res_status_next = pat_pkg::ST_DONE;
                            res_pos_next    = cmp_idx_reg;
                            if (ptr_reg > {1'b0, cmp_idx_reg})
                            begin
                                ptr_next = ptr_reg - PW'(1);
                            end
                            // prefetch the entry above the hole
                            idx_next   = cmp_idx_reg;
                            raddr      = (cmp_plus1 < PW'(DEPTH)) ?
                                         cmp_plus1[AW-1:0] : cmp_idx_reg;
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            res_status_next = pat_pkg::ST_DONE;
                            res_pos_next    = cmp_idx_reg;
                            state_next      = S_RESP;
                        end
                    endcase
                end
                else if (at_end)
                begin
                    if (op_reg == pat_pkg::OP_INSERT)
                    begin
                        we              = 1'b1;
                        waddr           = ins_slot;
                        wdata           = addr_reg;
                        ptr_next        = {1'b0, ins_slot} + PW'(1);
                        res_status_next = pat_pkg::ST_DONE;
                        res_pos_next    = ins_slot;
                    end
                    else
                    begin
                        res_status_next = pat_pkg::ST_ABSENT;
                    end
                    state_next = S_RESP;
                end
            end

            S_SHIFT:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                if (idx_reg == LAST)
                begin
                    wdata      = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    // rdata holds the entry above idx
                    wdata    = rdata_reg;
                    raddr    = (idx_plus2 < PW'(DEPTH)) ? idx_plus2[AW-1:0] : idx_reg;
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = PosW'(res_pos_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            cmp_idx_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

### hdl/peer_address_table_top.sv
// ----------------------------------------------------------------------------
// peer_address_table_top
// table of IPv4 peer addresses with lookup, ring insert and compacting remove
// ----------------------------------------------------------------------------
// After reset the table memory is cleared one entry per cycle, so req.ready
// stays low until the clear pass is done. Every operation that needs the
// table walks the table memory, which has one read and one write port, one
// entry per clock from slot 0 up to a match, the first empty entry or the
// last slot. A lookup or an insert pops its command, scans the table and
// then loads the response register. A remove that hits takes the same time
// wherever the entry lies, since the scan up to the slot and the shift of
// the later entries down one at a time together cover the whole table, and
// it is also the longest operation. Requests that need no table access (zero
// address, filtered private address) go from the pop straight to the
// response register. A two-entry command queue lets requests be taken while
// a scan runs, the back end loads a result only once the response register
// is free, and that register holds a result until taken.
module peer_address_table_top
#(
    parameter int DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    pat_req_if.sink    req,
    pat_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    logic          push;
    pat_pkg::cmd_t push_cmd;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    pat_pkg::cmd_t head;
    logic          clearing;

    pat_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .clearing   (clearing),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    pat_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    pat_back #(.DEPTH(DEPTH)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .clearing    (clearing),
        .rsp         (rsp)
    );

endmodule

### hdl/pat_checker.sv
// ----------------------------------------------------------------------------
// pat_checker
// port-level checks on the peer address table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pat_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pat_pkg::STATUS_W-1:0]  rsp_status,
    input logic [pat_pkg::POS_W-1:0]     rsp_position
);

    logic                                          rsp_stall;
    logic                                          rsp_failed;
    logic [pat_pkg::STATUS_W+pat_pkg::POS_W-1:0]   rsp_payload;

    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign rsp_failed  = rsp_valid && (rsp_status != pat_pkg::ST_DONE);
    assign rsp_payload = {rsp_status, rsp_position};

    // a stalled response transaction stays offered
    `PAT_ASSERT(a_rsp_hold, $past(rsp_stall) |-> rsp_valid, "rsp valid dropped")

    `PAT_ASSERT(a_rsp_stable, $past(rsp_stall) |-> $stable(rsp_payload), "rsp payload changed")

    // failed operations report slot zero
    `PAT_ASSERT(a_pos_zero, rsp_failed |-> rsp_position == '0, "position set on failure")

    // nothing moves in reset, and the clear pass blocks requests right after
    `PAT_ASSERT_ALWAYS(a_reset_quiet, !rst_n || $rose(rst_n) |-> !rsp_valid && !req_ready, "busy in reset")

endmodule

bind peer_address_table_top pat_checker u_pat_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position)
);

### bench/tb_peer_address_table_top.sv
// ----------------------------------------------------------------------------
// tb_peer_address_table_top
// self-checking bench for the peer address table: a short table of directed
// transactions, then random lookups, inserts and removes under both filter
// settings, results checked in order against a pin or a mirror of the table
// ----------------------------------------------------------------------------
module tb_peer_address_table_top;

    import pat_pkg::*;

    localparam int DEPTH      = 64;
    localparam int WATCHDOG   = 2000;
    localparam int LONG_HOLD  = 200;
    localparam int MAX_SHOWN  = 10;

    // the kind decoder treats the unused code as a lookup
    localparam logic [KIND_W-1:0] KIND_ALIAS = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [POS_W-1:0]    position;
    } outcome_t;

    typedef struct packed {
        logic                pinned;
        outcome_t            outcome;
    } pin_t;

    typedef struct packed {
        logic                filt;
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   address;
        logic                pinned;
        status_t             status;
        logic [POS_W-1:0]    position;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    pat_req_if req_ch ();
    pat_rsp_if rsp_ch ();

    peer_address_table_top #(.DEPTH(DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // mirror of the table state
    logic [ADDR_W-1:0] slots [DEPTH];
    logic [6:0]        ins_ptr;
    logic              filter_on;

    pin_t              pin_q [$];
    outcome_t          expect_q [$];
    logic [ADDR_W-1:0] seen_q [$];

    int  n_errors;
    int  n_results;
    int  n_lookups;
    int  n_inserts;
    int  n_removes;
    int  n_written;
    int  n_rejected;
    int  n_wraps;
    int  idle_cycles;
    bit  stall_req;
    bit  calm;

    row_t plan [25] = '{
        '{1'b0, KIND_LOOKUP, 32'h0102_0304, 1'b1, ST_ABSENT,  6'd0},
        '{1'b0, KIND_INSERT, 32'h0000_0000, 1'b1, ST_ZERO,    6'd0},
        '{1'b0, KIND_LOOKUP, 32'h0000_0000, 1'b1, ST_ABSENT,  6'd0},
        '{1'b0, KIND_REMOVE, 32'h0000_0000, 1'b1, ST_ABSENT,  6'd0},
        '{1'b0, KIND_INSERT, 32'hFFFF_FFFF, 1'b1, ST_DONE,    6'd0},
        '{1'b0, KIND_INSERT, 32'h0000_0001, 1'b1, ST_DONE,    6'd1},
        '{1'b0, KIND_INSERT, 32'h0A00_0001, 1'b1, ST_DONE,    6'd2},
        '{1'b0, KIND_INSERT, 32'hFFFF_FFFF, 1'b1, ST_PRESENT, 6'd0},
        '{1'b0, KIND_ALIAS,  32'h0000_0001, 1'b0, ST_DONE,    6'd0},
        '{1'b0, KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, ST_DONE,    6'd0},
        '{1'b0, KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, ST_DONE,    6'd0},
        '{1'b0, KIND_LOOKUP, 32'h0000_0001, 1'b0, ST_DONE,    6'd0},
        '{1'b0, KIND_INSERT, 32'h8000_0000, 1'b0, ST_DONE,    6'd0},
        '{1'b0, KIND_REMOVE, 32'h1234_5678, 1'b1, ST_ABSENT,  6'd0},
        '{1'b1, KIND_INSERT, 32'h0AFF_FFFF, 1'b1, ST_PRIVATE, 6'd0},
        '{1'b1, KIND_INSERT, 32'hAC10_0000, 1'b1, ST_PRIVATE, 6'd0},
        '{1'b1, KIND_INSERT, 32'hAC1F_FFFF, 1'b1, ST_PRIVATE, 6'd0},
        '{1'b1, KIND_INSERT, 32'hAC0F_0001, 1'b0, ST_DONE,    6'd0},
        '{1'b1, KIND_INSERT, 32'hAC20_0001, 1'b0, ST_DONE,    6'd0},
        '{1'b1, KIND_INSERT, 32'hC0A8_0101, 1'b1, ST_PRIVATE, 6'd0},
        '{1'b1, KIND_INSERT, 32'hA9FE_0001, 1'b1, ST_PRIVATE, 6'd0},
        '{1'b1, KIND_INSERT, 32'hC0A9_0001, 1'b0, ST_DONE,    6'd0},
        '{1'b1, KIND_INSERT, 32'h0000_0000, 1'b1, ST_ZERO,    6'd0},
        '{1'b1, KIND_ALIAS,  32'h0A00_0001, 1'b0, ST_DONE,    6'd0},
        '{1'b0, KIND_REMOVE, 32'h0A00_0001, 1'b0, ST_DONE,    6'd0}
    };

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // table mirror
    // ------------------------------------------------------------------
    function automatic int slot_of(input logic [ADDR_W-1:0] a);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slots[i] == '0)
                return DEPTH;
            if (slots[i] == a)
                return i;
        end
        return DEPTH;
    endfunction

    function automatic bit blocked_range(input logic [ADDR_W-1:0] a);
        logic [7:0] hi;
        logic [7:0] nx;
        hi = a[31:24];
        nx = a[23:16];
        if (hi == 8'd10)
            return 1'b1;
        if (hi == 8'd172 && nx >= 8'd16 && nx <= 8'd31)
            return 1'b1;
        if (hi == 8'd192 && nx == 8'd168)
            return 1'b1;
        return hi == 8'd169 && nx == 8'd254;
    endfunction

    function automatic outcome_t apply_op(input logic [KIND_W-1:0] k,
                                          input logic [ADDR_W-1:0] a);
        outcome_t o;
        int       s;
        o.status   = ST_ABSENT;
        o.position = '0;
        if (k == KIND_INSERT)
        begin
            if (a == '0)
                o.status = ST_ZERO;
            else if (filter_on && blocked_range(a))
                o.status = ST_PRIVATE;
            else if (slot_of(a) < DEPTH)
                o.status = ST_PRESENT;
            else
            begin
                if (ins_ptr >= DEPTH)
                begin
                    ins_ptr = '0;
                    n_wraps++;
                end
                slots[ins_ptr] = a;
                o.position     = ins_ptr[POS_W-1:0];
                o.status       = ST_DONE;
                ins_ptr        = ins_ptr + 7'd1;
            end
        end
        else
        begin
            s = (a == '0) ? DEPTH : slot_of(a);
            if (s < DEPTH)
            begin
                if (k == KIND_REMOVE)
                begin
                    if (ins_ptr > s)
                        ins_ptr = ins_ptr - 7'd1;
                    for (int i = s; i < DEPTH - 1; i++)
                        slots[i] = slots[i + 1];
                    slots[DEPTH - 1] = '0;
                end
                o.position = s[POS_W-1:0];
                o.status   = ST_DONE;
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // address choice for random transactions
    // ------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] private_or_near();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return {8'd10, r[23:0]};
            1: return {8'd172, 8'($urandom_range(16, 31)), r[15:0]};
            2: return {8'd192, 8'd168, r[15:0]};
            3: return {8'd169, 8'd254, r[15:0]};
            4: return {8'd172, ($urandom_range(0, 1) ? 8'd15 : 8'd32), r[15:0]};
            5: return {8'd192, 8'd169, r[15:0]};
            6: return {8'd169, 8'd253, r[15:0]};
            default: return {8'd11, r[23:0]};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] choose_address();
        int r;
        int used;
        r    = $urandom_range(0, 99);
        used = 0;
        while (used < DEPTH && slots[used] != '0)
            used++;
        if (r < 45 && used > 0)
            return slots[$urandom_range(0, used - 1)];
        if (r < 65)
            return $urandom;
        if (r < 77)
            return private_or_near();
        if (r < 92 && seen_q.size() > 0)
            return seen_q[$urandom_range(0, seen_q.size() - 1)];
        if (r < 95)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
        return '0;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic offer(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                         input logic pinned, input outcome_t o);
        pin_t p;
        p.pinned  = pinned;
        p.outcome = o;
        pin_q.push_back(p);
        if (a != '0)
        begin
            seen_q.push_back(a);
            if (seen_q.size() > 200)
                void'(seen_q.pop_front());
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= k;
        req_ch.address <= a;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pin_q.size() != 0 || expect_q.size() != 0);
    endtask

    task automatic write_filter(input logic v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int ins_pct, input int rem_pct,
                             input int fresh_pct, input bit pause_mid);
        int               r;
        bit               gappy;
        logic [KIND_W-1:0] k;
        logic [ADDR_W-1:0] a;
        outcome_t         none;
        none.status   = ST_ABSENT;
        none.position = '0;
        gappy = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            // gaps come and go in stretches of 32 transactions
            if (i % 32 == 0)
                gappy = !calm && ($urandom_range(0, 3) != 0);
            if (pause_mid && i == n / 2)
                drain();
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                k = KIND_INSERT;
            else if (r < ins_pct + rem_pct)
                k = KIND_REMOVE;
            else
                k = ($urandom_range(0, 4) == 0) ? KIND_ALIAS : KIND_LOOKUP;
            if ($urandom_range(0, 99) < fresh_pct)
                a = $urandom;
            else
                a = choose_address();
            offer(k, a, 1'b0, none);
            if (gappy && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        outcome_t o;
        clk            = 1'b0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_LOOKUP;
        req_ch.address <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (i == 0 || plan[i].filt != filter_on)
                write_filter(plan[i].filt);
            o.status   = plan[i].status;
            o.position = plan[i].position;
            offer(plan[i].kind, plan[i].address, plan[i].pinned, o);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 6));
        end

        // insert-heavy so the ring pointer wraps
        write_filter(1'b0);
        run_phase(140, 70, 10, 60, 1'b0);

        write_filter(1'b1);
        run_phase(120, 40, 25, 10, 1'b1);

        // receiver holds off while requests keep coming
        write_filter(1'b0);
        stall_req = 1'b1;
        run_phase(100, 25, 45, 10, 1'b0);

        write_filter(1'b1);
        calm = 1'b1;
        run_phase(60, 35, 30, 20, 1'b0);

        drain();
        repeat (2 * DEPTH + 20) @(posedge clk);

        $display("covered %0d transactions: %0d lookups, %0d inserts, %0d removes, filter on and off",
                 n_lookups + n_inserts + n_removes, n_lookups, n_inserts, n_removes);
        $display("%0d inserts written, %0d rejected, %0d pointer wraps, %0d results checked",
                 n_written, n_rejected, n_wraps, n_results);
        if (n_errors == 0 && expect_q.size() == 0)
            $display("tb_peer_address_table_top: PASS");
        else
            $display("tb_peer_address_table_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // response side: random backpressure plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                stall_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor, checker and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        foreach (slots[i])
            slots[i] = '0;
        ins_ptr   = '0;
        filter_on = 1'b0;
    end

    always @(posedge clk)
    begin
        pin_t     p;
        outcome_t got;
        outcome_t want;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_we)
                filter_on = cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                p   = pin_q.pop_front();
                got = apply_op(req_ch.kind, req_ch.address);
                expect_q.push_back(p.pinned ? p.outcome : got);
                if (req_ch.kind == KIND_INSERT)
                begin
                    n_inserts++;
                    if (got.status == ST_DONE)
                        n_written++;
                    else
                        n_rejected++;
                end
                else if (req_ch.kind == KIND_REMOVE)
                    n_removes++;
                else
                    n_lookups++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                n_results++;
                if (expect_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("unexpected result: status %0d position %0d",
                                 rsp_ch.status, rsp_ch.position);
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (want.status !== rsp_ch.status || want.position !== rsp_ch.position)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                            $display("result %0d: status exp %0d got %0d, position exp %0d got %0d",
                                     n_results, want.status, rsp_ch.status,
                                     want.position, rsp_ch.position);
                    end
                end
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         WATCHDOG, expect_q.size() + pin_q.size());
                $display("tb_peer_address_table_top: FAIL");
                $finish;
            end
        end
    end

endmodule

### files.f
+incdir+hdl
hdl/pat_pkg.sv
hdl/pat_if.sv
hdl/pat_front.sv
hdl/pat_queue.sv
hdl/pat_back.sv
hdl/peer_address_table_top.sv
hdl/pat_checker.sv
bench/tb_peer_address_table_top.sv
